// ===== hw/rtl/bcd_clock_calendar_alarm_macros.svh =====
// ----------------------------------------------------------------------------
// bcd_clock_calendar_alarm_macros
// Assertion macros shared by the clock and calendar RTL.
// ----------------------------------------------------------------------------
`ifndef BCD_CLOCK_CALENDAR_ALARM_MACROS_SVH
`define BCD_CLOCK_CALENDAR_ALARM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCDCAL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bcdcal assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BCDCAL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bcdcal assertion failed");

`endif

// ===== hw/rtl/bcdcal_pkg.sv =====
// ----------------------------------------------------------------------------
// bcdcal_pkg
// Types, reset constants and BCD helper functions for the clock and calendar.
// ----------------------------------------------------------------------------
`default_nettype none

package bcdcal_pkg;

    localparam int unsigned W_SEC   = 7;
    localparam int unsigned W_MIN   = 7;
    localparam int unsigned W_HOUR  = 5;
    localparam int unsigned W_DAY   = 6;
    localparam int unsigned W_MONTH = 5;
    localparam int unsigned W_YEAR  = 8;
    localparam int unsigned W_CFG_INDEX = 2;
    localparam int unsigned W_CFG_DATA  = 7;

    typedef enum logic [W_CFG_INDEX-1:0] {
        CFG_ALARM_HOUR   = 2'd0,
        CFG_ALARM_MINUTE = 2'd1,
        CFG_ALARM_ENABLE = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [W_SEC-1:0]   seconds_bcd;
        logic [W_MIN-1:0]   minutes_bcd;
        logic [W_HOUR-1:0]  hours_bcd;
        logic [W_DAY-1:0]   day_bcd;
        logic [W_MONTH-1:0] month_bcd;
        logic [W_YEAR-1:0]  year_bcd;
        logic               alarm_match;
    } t_time;

    typedef struct packed {
        logic [W_HOUR-1:0] hour;
        logic [W_MIN-1:0]  minute;
        logic              enable;
    } t_alarm_cfg;

    localparam t_time TIME_RESET = '{
        seconds_bcd: 7'h00,
        minutes_bcd: 7'h07,
        hours_bcd:   5'h03,
        day_bcd:     6'h11,
        month_bcd:   5'h10,
        year_bcd:    8'h18,
        alarm_match: 1'b0
    };

    localparam t_alarm_cfg ALARM_RESET = '{
        hour:   5'h01,
        minute: 7'h00,
        enable: 1'b0
    };

    // Two-digit BCD increment; 99 wraps to 00.
    function automatic logic [7:0] bcd_next(input logic [7:0] v);
        logic [7:0] r;
        if (v >= 8'h99) begin
            r = 8'h00;
        end else if (v[3:0] >= 4'd9) begin
            r = {v[7:4] + 4'd1, 4'd0};
        end else begin
            r = v + 8'd1;
        end
        return r;
    endfunction

    // Last day of the month in BCD, with no leap years.
    function automatic logic [W_DAY-1:0] last_day(input logic [W_MONTH-1:0] month);
        logic [W_DAY-1:0] d;
        case (month)
            5'h02:                      d = 6'h28;
            5'h04, 5'h06, 5'h09, 5'h11: d = 6'h30;
            default:                    d = 6'h31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bcdcal_tick_if.sv =====
// ----------------------------------------------------------------------------
// bcdcal_tick_if
// Input channel carrying one second tick flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcdcal_tick_if;
    logic valid;
    logic ready;
    logic second_tick;

    modport source (output valid, output second_tick, input ready);
    modport sink (input valid, input second_tick, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bcdcal_time_if.sv =====
// ----------------------------------------------------------------------------
// bcdcal_time_if
// Result channel carrying the time, date and alarm match per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcdcal_time_if;
    logic                            valid;
    logic                            ready;
    logic [bcdcal_pkg::W_SEC-1:0]    seconds_bcd;
    logic [bcdcal_pkg::W_MIN-1:0]    minutes_bcd;
    logic [bcdcal_pkg::W_HOUR-1:0]   hours_bcd;
    logic [bcdcal_pkg::W_DAY-1:0]    day_bcd;
    logic [bcdcal_pkg::W_MONTH-1:0]  month_bcd;
    logic [bcdcal_pkg::W_YEAR-1:0]   year_bcd;
    logic                            alarm_match;

    modport source (
        output valid, output seconds_bcd, output minutes_bcd, output hours_bcd,
        output day_bcd, output month_bcd, output year_bcd, output alarm_match,
        input ready
    );
    modport sink (
        input valid, input seconds_bcd, input minutes_bcd, input hours_bcd,
        input day_bcd, input month_bcd, input year_bcd, input alarm_match,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/bcdcal_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bcdcal_cfg_if
// Register write channel carrying an index and write data per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcdcal_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bcdcal_pkg::W_CFG_INDEX-1:0]  index;
    logic [bcdcal_pkg::W_CFG_DATA-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bcdcal_time_core.sv =====
// ----------------------------------------------------------------------------
// bcdcal_time_core
// Cascaded BCD time and date counters with the alarm compare.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bcd_clock_calendar_alarm_macros.svh"

module bcdcal_time_core (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_step,
    input  wire logic                    i_tick,
    input  wire bcdcal_pkg::t_alarm_cfg  i_alarm,
    output bcdcal_pkg::t_time            o_next
);

    bcdcal_pkg::t_time r_time;
    bcdcal_pkg::t_time n_time;
    logic              r_half_day;
    logic              n_half_day;

    logic [7:0] w_sec_inc;
    logic [7:0] w_min_inc;
    logic [7:0] w_hour_inc;
    logic [7:0] w_day_inc;
    logic [7:0] w_month_inc;
    logic [7:0] w_year_inc;

    assign w_sec_inc   = bcdcal_pkg::bcd_next({1'b0, r_time.seconds_bcd});
    assign w_min_inc   = bcdcal_pkg::bcd_next({1'b0, r_time.minutes_bcd});
    assign w_hour_inc  = bcdcal_pkg::bcd_next({3'b000, r_time.hours_bcd});
    assign w_day_inc   = bcdcal_pkg::bcd_next({2'b00, r_time.day_bcd});
    assign w_month_inc = bcdcal_pkg::bcd_next({3'b000, r_time.month_bcd});
    assign w_year_inc  = bcdcal_pkg::bcd_next(r_time.year_bcd);

    always_comb begin
        n_time     = r_time;
        n_half_day = r_half_day;
        if (i_tick) begin
            if (r_time.seconds_bcd[3:0] >= 4'd9) begin
                n_time.alarm_match = i_alarm.enable
                                  && (r_time.minutes_bcd == i_alarm.minute)
                                  && (r_time.hours_bcd == i_alarm.hour);
            end
            if (r_time.seconds_bcd >= 7'h59) begin
                n_time.seconds_bcd = '0;
                if (r_time.minutes_bcd >= 7'h59) begin
                    n_time.minutes_bcd = '0;
                    if (r_time.hours_bcd >= 5'h12) begin
                        n_time.hours_bcd = 5'h01;
                        n_half_day       = ~r_half_day;
                        if (r_half_day) begin
                            if (r_time.day_bcd >= bcdcal_pkg::last_day(r_time.month_bcd)) begin
                                n_time.day_bcd = 6'h01;
                                if (r_time.month_bcd >= 5'h12) begin
                                    n_time.month_bcd = 5'h01;
                                    n_time.year_bcd  = w_year_inc;
                                end else begin
                                    n_time.month_bcd = w_month_inc[4:0];
                                end
                            end else begin
                                n_time.day_bcd = w_day_inc[5:0];
                            end
                        end
                    end else begin
                        n_time.hours_bcd = w_hour_inc[4:0];
                    end
                end else begin
                    n_time.minutes_bcd = w_min_inc[6:0];
                end
            end else begin
                n_time.seconds_bcd = w_sec_inc[6:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time     <= bcdcal_pkg::TIME_RESET;
            r_half_day <= 1'b0;
        end else if (i_step) begin
            r_time     <= n_time;
            r_half_day <= n_half_day;
        end
    end

    assign o_next = n_time;

    `BCDCAL_ASSERT_NXT(a_hold_without_tick, i_clk, i_rst_n, i_step && !i_tick,
                       $stable(r_time))
    `BCDCAL_ASSERT_IMP(a_sec_units_bcd, i_clk, i_rst_n, 1'b1,
                       r_time.seconds_bcd[3:0] <= 4'd9)
    `BCDCAL_ASSERT_IMP(a_hour_range, i_clk, i_rst_n, 1'b1,
                       (r_time.hours_bcd != 5'h00) && (r_time.hours_bcd <= 5'h12))
    `BCDCAL_ASSERT_NXT(a_flag_at_wrap, i_clk, i_rst_n,
                       !(i_step && i_tick && (r_time.seconds_bcd[3:0] == 4'd9)),
                       $stable(r_time.alarm_match))

endmodule

`default_nettype wire

// ===== hw/rtl/bcd_clock_calendar_alarm.sv =====
// ----------------------------------------------------------------------------
// bcd_clock_calendar_alarm
// A tick beat is held in the input register until the result register can take it.
// Throughput: one tick beat per cycle while the result channel is not stalled.
// An input register and a result register separate the two channels.
// Synchronous active-low reset loads the start time 03:07:00, 11 Oct 18.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bcd_clock_calendar_alarm_macros.svh"

module bcd_clock_calendar_alarm (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    bcdcal_tick_if.sink       i_tick,
    bcdcal_cfg_if.sink        i_cfg,
    bcdcal_time_if.source     o_time
);

    logic                    r_s1_valid;
    logic                    r_s1_tick;
    logic                    r_out_valid;
    bcdcal_pkg::t_time       r_out;
    bcdcal_pkg::t_time       w_next;
    bcdcal_pkg::t_alarm_cfg  r_alarm;
    logic                    w_out_load;
    logic                    w_in_fire;

    assign w_out_load   = r_s1_valid && (!r_out_valid || o_time.ready);
    assign i_tick.ready = !r_s1_valid || w_out_load;
    assign w_in_fire    = i_tick.valid && i_tick.ready;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm <= bcdcal_pkg::ALARM_RESET;
        end else if (i_cfg.valid) begin
            unique case (bcdcal_pkg::t_cfg_index'(i_cfg.index))
                bcdcal_pkg::CFG_ALARM_HOUR: begin
                    r_alarm.hour <= i_cfg.data[bcdcal_pkg::W_HOUR-1:0];
                end
                bcdcal_pkg::CFG_ALARM_MINUTE: begin
                    r_alarm.minute <= i_cfg.data[bcdcal_pkg::W_MIN-1:0];
                end
                bcdcal_pkg::CFG_ALARM_ENABLE: begin
                    r_alarm.enable <= i_cfg.data[0];
                end
                default: begin
                    r_alarm <= r_alarm;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_tick.ready) begin
            r_s1_valid <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_tick <= i_tick.second_tick;
        end
    end

    bcdcal_time_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_out_load),
        .i_tick  (r_s1_tick),
        .i_alarm (r_alarm),
        .o_next  (w_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_time.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_next;
        end
    end

    assign o_time.valid       = r_out_valid;
    assign o_time.seconds_bcd = r_out.seconds_bcd;
    assign o_time.minutes_bcd = r_out.minutes_bcd;
    assign o_time.hours_bcd   = r_out.hours_bcd;
    assign o_time.day_bcd     = r_out.day_bcd;
    assign o_time.month_bcd   = r_out.month_bcd;
    assign o_time.year_bcd    = r_out.year_bcd;
    assign o_time.alarm_match = r_out.alarm_match;

    `BCDCAL_ASSERT_NXT(a_load_sets_out, i_clk, i_rst_n, w_out_load, r_out_valid)
    `BCDCAL_ASSERT_NXT(a_stage_kept, i_clk, i_rst_n, r_s1_valid && !w_out_load, r_s1_valid)
    `BCDCAL_ASSERT_IMP(a_stall_means_full, i_clk, i_rst_n, !i_tick.ready, r_s1_valid && r_out_valid)

endmodule

`default_nettype wire

// ===== test/tb_bcd_clock_calendar_alarm.sv =====
// ----------------------------------------------------------------------------
// tb_bcd_clock_calendar_alarm
// Self-checking bench for the BCD clock and calendar with alarm compare.
// Tick beats are driven from a queue. A local model of the counters predicts
// every result beat, and each result is compared field by field in order.
// Alarm registers change only while the block is drained. Random phases mix
// holds and steps across many minute wraps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bcd_clock_calendar_alarm;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [bcdcal_pkg::W_CFG_INDEX-1:0] CFG_INDEX_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_TICKS    = 130;

    typedef struct packed {
        logic [bcdcal_pkg::W_SEC-1:0]   sec;
        logic [bcdcal_pkg::W_MIN-1:0]   min;
        logic [bcdcal_pkg::W_HOUR-1:0]  hour;
        logic                           pm;
        logic [bcdcal_pkg::W_DAY-1:0]   day;
        logic [bcdcal_pkg::W_MONTH-1:0] month;
        logic [bcdcal_pkg::W_YEAR-1:0]  year;
        logic                           alarm;
    } t_clock_state;

    typedef struct packed {
        logic [bcdcal_pkg::W_CFG_INDEX-1:0] index;
        logic [bcdcal_pkg::W_CFG_DATA-1:0]  data;
    } t_reg_write;

    typedef enum int {
        ALARM_AT_NOW,
        ALARM_EXTREME,
        ALARM_RAW,
        ALARM_KEEP
    } t_alarm_mode;

    localparam t_clock_state CLOCK_START = '{
        sec: 7'h00, min: 7'h07, hour: 5'h03, pm: 1'b0,
        day: 6'h11, month: 5'h10, year: 8'h18, alarm: 1'b0
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bcdcal_tick_if tick_bus ();
    bcdcal_cfg_if  cfg_bus ();
    bcdcal_time_if time_bus ();

    bcd_clock_calendar_alarm DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_tick  (tick_bus),
        .i_cfg   (cfg_bus),
        .o_time  (time_bus)
    );

    t_clock_state                  clock_now;
    logic [bcdcal_pkg::W_HOUR-1:0] alarm_hour_reg;
    logic [bcdcal_pkg::W_MIN-1:0]  alarm_minute_reg;
    logic                          alarm_enable_reg;

    logic              pending_ticks[$];
    t_reg_write        pending_writes[$];
    bcdcal_pkg::t_time expected_times[$];

    int tick_idle_pct   = 0;
    int result_idle_pct = 0;
    int error_count     = 0;
    int ticks_sent      = 0;
    int writes_done     = 0;
    int results_seen    = 0;
    int alarm_beats     = 0;
    int hour_wraps      = 0;
    int day_advances    = 0;
    int stall_cycles    = 0;

    always #4 clk = ~clk;

    function automatic logic [7:0] bcd_inc(input logic [7:0] v);
        logic [3:0] ones;
        logic [3:0] tens;
        ones = v[3:0];
        tens = v[7:4];
        if (v >= 8'h99) begin
            ones = 4'd0;
            tens = 4'd0;
        end else if (ones >= 4'd9) begin
            ones = 4'd0;
            tens = tens + 4'd1;
        end else begin
            ones = ones + 4'd1;
        end
        return {tens, ones};
    endfunction

    function automatic logic [bcdcal_pkg::W_DAY-1:0] month_length(
        input logic [bcdcal_pkg::W_MONTH-1:0] m
    );
        if (m == 5'h02) return 6'h28;
        if (m == 5'h04 || m == 5'h06 || m == 5'h09 || m == 5'h11) return 6'h30;
        return 6'h31;
    endfunction

    // The alarm compare uses the minute and hour before this tick carries into them.
    function automatic t_clock_state clock_after_tick(input t_clock_state s);
        logic [7:0] nxt;
        if (s.sec[3:0] >= 4'd9) begin
            s.alarm = alarm_enable_reg && s.min == alarm_minute_reg &&
                      s.hour == alarm_hour_reg;
        end
        if (s.sec >= 7'h59) begin
            s.sec = '0;
            if (s.min >= 7'h59) begin
                s.min = '0;
                if (s.hour >= 5'h12) begin
                    s.hour = 5'h01;
                    s.pm = ~s.pm;
                    if (!s.pm) begin
                        if (s.day >= month_length(s.month)) begin
                            s.day = 6'h01;
                            if (s.month >= 5'h12) begin
                                s.month = 5'h01;
                                s.year = bcd_inc(s.year);
                            end else begin
                                nxt = bcd_inc({3'b0, s.month});
                                s.month = nxt[bcdcal_pkg::W_MONTH-1:0];
                            end
                        end else begin
                            nxt = bcd_inc({2'b0, s.day});
                            s.day = nxt[bcdcal_pkg::W_DAY-1:0];
                        end
                    end
                end else begin
                    nxt = bcd_inc({3'b0, s.hour});
                    s.hour = nxt[bcdcal_pkg::W_HOUR-1:0];
                end
            end else begin
                nxt = bcd_inc({1'b0, s.min});
                s.min = nxt[bcdcal_pkg::W_MIN-1:0];
            end
        end else begin
            nxt = bcd_inc({1'b0, s.sec});
            s.sec = nxt[bcdcal_pkg::W_SEC-1:0];
        end
        return s;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= 10) begin
                $display("Mismatch on result beat %0d, %s: expected %h, got %h",
                         results_seen, name, want, got);
            end
        end
    endfunction

    always @(posedge clk) begin : drive_inputs
        t_clock_state      next_state;
        bcdcal_pkg::t_time beat;
        if (!rst_n) begin
            tick_bus.valid   <= 1'b0;
            cfg_bus.valid    <= 1'b0;
            clock_now        = CLOCK_START;
            alarm_hour_reg   = 5'h01;
            alarm_minute_reg = 7'h00;
            alarm_enable_reg = 1'b0;
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.index)
                    bcdcal_pkg::CFG_ALARM_HOUR: begin
                        alarm_hour_reg = cfg_bus.data[bcdcal_pkg::W_HOUR-1:0];
                    end
                    bcdcal_pkg::CFG_ALARM_MINUTE: begin
                        alarm_minute_reg = cfg_bus.data[bcdcal_pkg::W_MIN-1:0];
                    end
                    bcdcal_pkg::CFG_ALARM_ENABLE: begin
                        alarm_enable_reg = cfg_bus.data[0];
                    end
                    default: begin
                    end
                endcase
                void'(pending_writes.pop_front());
                writes_done++;
            end
            if (tick_bus.valid && tick_bus.ready) begin
                if (tick_bus.second_tick) begin
                    next_state = clock_after_tick(clock_now);
                    if (clock_now.hour == 5'h12 && next_state.hour == 5'h01) hour_wraps++;
                    if (next_state.day != clock_now.day) day_advances++;
                    clock_now = next_state;
                end
                beat.seconds_bcd = clock_now.sec;
                beat.minutes_bcd = clock_now.min;
                beat.hours_bcd   = clock_now.hour;
                beat.day_bcd     = clock_now.day;
                beat.month_bcd   = clock_now.month;
                beat.year_bcd    = clock_now.year;
                beat.alarm_match = clock_now.alarm;
                expected_times.push_back(beat);
                void'(pending_ticks.pop_front());
                ticks_sent++;
            end
            if (!(cfg_bus.valid && !cfg_bus.ready)) begin
                if (pending_writes.size() != 0 && $urandom_range(99) >= tick_idle_pct) begin
                    cfg_bus.valid <= 1'b1;
                    cfg_bus.index <= pending_writes[0].index;
                    cfg_bus.data  <= pending_writes[0].data;
                end else begin
                    cfg_bus.valid <= 1'b0;
                end
            end
            if (!(tick_bus.valid && !tick_bus.ready)) begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= tick_idle_pct) begin
                    tick_bus.valid       <= 1'b1;
                    tick_bus.second_tick <= pending_ticks[0];
                end else begin
                    tick_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : check_results
        bcdcal_pkg::t_time want;
        if (!rst_n) begin
            time_bus.ready <= 1'b0;
        end else begin
            if (time_bus.valid && time_bus.ready) begin
                results_seen++;
                if (expected_times.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("Unexpected result beat %0d with nothing predicted",
                                 results_seen);
                    end
                end else begin
                    want = expected_times.pop_front();
                    compare_field("seconds", 8'(want.seconds_bcd), 8'(time_bus.seconds_bcd));
                    compare_field("minutes", 8'(want.minutes_bcd), 8'(time_bus.minutes_bcd));
                    compare_field("hours", 8'(want.hours_bcd), 8'(time_bus.hours_bcd));
                    compare_field("day", 8'(want.day_bcd), 8'(time_bus.day_bcd));
                    compare_field("month", 8'(want.month_bcd), 8'(time_bus.month_bcd));
                    compare_field("year", want.year_bcd, time_bus.year_bcd);
                    compare_field("alarm_match", 8'(want.alarm_match),
                                  8'(time_bus.alarm_match));
                    if (want.alarm_match) alarm_beats++;
                end
            end
            time_bus.ready <= ($urandom_range(99) >= result_idle_pct);
        end
    end

    always @(posedge clk) begin : watchdog
        if (!rst_n || (tick_bus.valid && tick_bus.ready) || (cfg_bus.valid && cfg_bus.ready)
                || (time_bus.valid && time_bus.ready)) begin
            stall_cycles = 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles++;
        end
    end

    task automatic settle();
        while (pending_ticks.size() != 0 || pending_writes.size() != 0 || tick_bus.valid
               || cfg_bus.valid || expected_times.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bcdcal_pkg::W_CFG_INDEX-1:0] index,
                             input logic [bcdcal_pkg::W_CFG_DATA-1:0] data);
        t_reg_write w;
        w.index = index;
        w.data  = data;
        pending_writes.push_back(w);
    endtask

    task automatic finish_writes();
        while (pending_writes.size() != 0 || cfg_bus.valid) @(posedge clk);
    endtask

    task automatic push_ticks(input int count, input int one_pct);
        repeat (count) pending_ticks.push_back($urandom_range(99) < one_pct);
    endtask

    initial begin : run
        int          phase;
        int          one_pct;
        t_alarm_mode mode;
        logic [7:0]  minute_pick;

        tick_bus.valid       = 1'b0;
        tick_bus.second_tick = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = bcdcal_pkg::CFG_ALARM_HOUR;
        cfg_bus.data         = '0;
        time_bus.ready       = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // Reset alarm settings, holds mixed with steps.
        pending_ticks.push_back(1'b0);
        pending_ticks.push_back(1'b1);
        pending_ticks.push_back(1'b0);
        pending_ticks.push_back(1'b1);
        settle();

        // Alarm at the reset time: the next units wrap sets the match.
        write_reg(bcdcal_pkg::CFG_ALARM_HOUR, 7'h03);
        write_reg(bcdcal_pkg::CFG_ALARM_MINUTE, 7'h07);
        write_reg(bcdcal_pkg::CFG_ALARM_ENABLE, 7'h01);
        finish_writes();
        push_ticks(8, 100);
        settle();

        // Disabling between compares leaves the match standing.
        write_reg(bcdcal_pkg::CFG_ALARM_ENABLE, 7'h7E);
        finish_writes();
        push_ticks(3, 100);
        settle();

        // Unused index is ignored; non-BCD alarm values never match.
        write_reg(CFG_INDEX_SPARE, 7'h01);
        write_reg(bcdcal_pkg::CFG_ALARM_HOUR, 7'h7F);
        write_reg(bcdcal_pkg::CFG_ALARM_MINUTE, 7'h7F);
        write_reg(bcdcal_pkg::CFG_ALARM_ENABLE, 7'h01);
        finish_writes();
        push_ticks(7, 100);
        settle();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            tick_idle_pct   = (phase == 2) ? 0 : 16;
            result_idle_pct = (phase == 2) ? 0 : 16;
            mode = (phase == 0) ? ALARM_EXTREME : t_alarm_mode'($urandom_range(4) % 4);
            if (phase == 1 || phase == 4) mode = ALARM_AT_NOW;
            case (mode)
                ALARM_AT_NOW: begin
                    minute_pick = $urandom_range(1) ? bcd_inc({1'b0, clock_now.min})
                                                    : {1'b0, clock_now.min};
                    write_reg(bcdcal_pkg::CFG_ALARM_HOUR, {2'b0, clock_now.hour});
                    write_reg(bcdcal_pkg::CFG_ALARM_MINUTE,
                              minute_pick[bcdcal_pkg::W_MIN-1:0]);
                end
                ALARM_EXTREME: begin
                    write_reg(bcdcal_pkg::CFG_ALARM_HOUR, $urandom_range(1) ? 7'h12 : 7'h01);
                    write_reg(bcdcal_pkg::CFG_ALARM_MINUTE, $urandom_range(1) ? 7'h59 : 7'h00);
                end
                ALARM_RAW: begin
                    write_reg(bcdcal_pkg::CFG_ALARM_HOUR,
                              bcdcal_pkg::W_CFG_DATA'($urandom_range(127)));
                    write_reg(bcdcal_pkg::CFG_ALARM_MINUTE,
                              bcdcal_pkg::W_CFG_DATA'($urandom_range(127)));
                end
                default: begin
                    write_reg(CFG_INDEX_SPARE, bcdcal_pkg::W_CFG_DATA'($urandom_range(127)));
                end
            endcase
            write_reg(bcdcal_pkg::CFG_ALARM_ENABLE,
                      {6'($urandom_range(63)), $urandom_range(3) != 0});
            finish_writes();
            one_pct = (phase == 3) ? 40 : 88;
            push_ticks(PHASE_TICKS, one_pct);
            settle();
        end

        // Closing run with the alarm set to the first minute of the hour count.
        tick_idle_pct   = 16;
        result_idle_pct = 16;
        write_reg(bcdcal_pkg::CFG_ALARM_HOUR, 7'h01);
        write_reg(bcdcal_pkg::CFG_ALARM_MINUTE, 7'h00);
        write_reg(bcdcal_pkg::CFG_ALARM_ENABLE, 7'h01);
        finish_writes();
        push_ticks(100, 90);
        settle();

        $display("Checked %0d result beats from %0d tick beats and %0d register writes.",
                 results_seen, ticks_sent, writes_done);
        $display("Alarm match held on %0d beats; %0d hour wraps and %0d day advances.",
                 alarm_beats, hour_wraps, day_advances);
        if (error_count == 0 && expected_times.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
